FILE: hdl/fir_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Shared constants, operation codes and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package fir_pkg;

   localparam int MAX_TAPS_DEF     = 512;
   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 24;

   localparam int TAP_REG_W    = 10;
   localparam int COEF_INDEX_W = 9;
   localparam int OUT_W        = 56;

   localparam logic [TAP_REG_W-1:0] TAP_RESET = 10'd512;

   localparam logic [1:0] OP_LOAD_COEF     = 2'd0;
   localparam logic [1:0] OP_PUSH_SAMPLE   = 2'd1;
   localparam logic [1:0] OP_CLEAR_HISTORY = 2'd2;

   typedef struct packed {
      logic load_coef;
      logic push_sample;
      logic clear_history;
      logic start_mac;
      logic issue_mac;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic window_full;
      logic last_issue;
      logic mac_busy;
   } status_type;

endpackage

FILE: hdl/fir_ram.sv
// ----------------------------------------------------------------------------
// FIR generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fir_ram #(
   parameter int WIDTH = fir_pkg::SAMPLE_WIDTH_DEF,
   parameter int DEPTH = fir_pkg::MAX_TAPS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/fir_datapath.sv
// ----------------------------------------------------------------------------
// FIR datapath
// Coefficient and history memories, pointers, fill count, the shared
// multiply-accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module fir_datapath #(
   parameter int MAX_TAPS     = fir_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = fir_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fir_pkg::cmd_type                     cmd,
   output fir_pkg::status_type                  status,
   input  logic [fir_pkg::COEF_INDEX_W-1:0]     req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]         req_coef_value,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   input  logic                                 csr_write_enable,
   input  logic [fir_pkg::TAP_REG_W-1:0]        csr_write_data,
   output logic signed [fir_pkg::OUT_W-1:0]     rsp_filtered_value
);

   localparam int ADDR_W = $clog2(MAX_TAPS);
   localparam int FILL_W = $clog2(MAX_TAPS + 1);
   localparam int CMP_W  = (FILL_W > fir_pkg::TAP_REG_W) ? FILL_W : fir_pkg::TAP_REG_W;
   localparam int SUM_W  = FILL_W + 1;
   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);

   logic [fir_pkg::TAP_REG_W-1:0]    tap_ff, tap_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [ADDR_W-1:0]                wp_ff, wp_in;
   logic [ADDR_W-1:0]                coef_addr_ff, coef_addr_in;
   logic [ADDR_W-1:0]                hist_addr_ff, hist_addr_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic                             prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [fir_pkg::OUT_W-1:0] acc_ff, acc_in;
   logic signed [fir_pkg::OUT_W-1:0] out_ff, out_in;

   logic [CMP_W-1:0]        tap_ext;
   logic [FILL_W-1:0]       tap_eff;
   logic [FILL_W-1:0]       back_off;
   logic [SUM_W-1:0]        start_sum;
   logic [ADDR_W-1:0]       start_pos;
   logic                    coef_wr_en;
   logic [COEF_WIDTH-1:0]   coef_rd;
   logic [SAMPLE_WIDTH-1:0] hist_rd;

   fir_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (ADDR_W'(req_coef_index)),
      .wr_data (req_coef_value),
      .rd_en   (cmd.issue_mac),
      .rd_addr (coef_addr_ff),
      .rd_data (coef_rd)
   );

   fir_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.push_sample),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_en   (cmd.issue_mac),
      .rd_addr (hist_addr_ff),
      .rd_data (hist_rd)
   );

   // A tap count of zero acts as one, and one above the memory depth as the depth.
   always_comb begin
      tap_ext = CMP_W'(tap_ff);
      if (tap_ext == '0) begin
         tap_eff = FILL_W'(1);
      end else if (tap_ext > CMP_W'(MAX_TAPS)) begin
         tap_eff = FILL_W'(MAX_TAPS);
      end else begin
         tap_eff = FILL_W'(tap_ext);
      end
      back_off  = FILL_W'(MAX_TAPS) - tap_eff;
      start_sum = SUM_W'(wp_ff) + SUM_W'(back_off);
      if (start_sum >= SUM_W'(MAX_TAPS)) begin
         start_pos = ADDR_W'(start_sum - SUM_W'(MAX_TAPS));
      end else begin
         start_pos = ADDR_W'(start_sum);
      end
   end

   assign coef_wr_en = cmd.load_coef && (32'(req_coef_index) < 32'(MAX_TAPS));

   always_comb begin
      tap_in       = csr_write_enable ? csr_write_data : tap_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      coef_addr_in = coef_addr_ff;
      hist_addr_in = hist_addr_ff;
      acc_in       = acc_ff;
      if (cmd.clear_history) begin
         fill_in = '0;
      end
      if (cmd.push_sample) begin
         wp_in = (wp_ff == LAST_ADDR) ? '0 : wp_ff + ADDR_W'(1);
         if (fill_ff != FILL_W'(MAX_TAPS)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      if (cmd.start_mac) begin
         coef_addr_in = '0;
         hist_addr_in = start_pos;
         acc_in       = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + fir_pkg::OUT_W'(prod_ff);
      end
      if (cmd.issue_mac) begin
         coef_addr_in = coef_addr_ff + ADDR_W'(1);
         hist_addr_in = (hist_addr_ff == LAST_ADDR) ? '0 : hist_addr_ff + ADDR_W'(1);
      end
      rd_vld_in   = cmd.issue_mac;
      prod_vld_in = rd_vld_ff;
      prod_in     = rd_vld_ff ? $signed(hist_rd) * $signed(coef_rd) : prod_ff;
      out_in      = cmd.publish ? acc_ff : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff      <= fir_pkg::TAP_RESET;
         fill_ff     <= '0;
         wp_ff       <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         tap_ff      <= tap_in;
         fill_ff     <= fill_in;
         wp_ff       <= wp_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_addr_ff <= coef_addr_in;
      hist_addr_ff <= hist_addr_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      out_ff       <= out_in;
   end

   assign status.window_full = (fill_ff >= tap_eff);
   assign status.last_issue  = (coef_addr_ff == ADDR_W'(tap_eff - FILL_W'(1)));
   assign status.mac_busy    = rd_vld_ff || prod_vld_ff;

   assign rsp_filtered_value = out_ff;

endmodule

FILE: hdl/fir_ctrl.sv
// ----------------------------------------------------------------------------
// FIR controller
// Accepts request beats, sequences the multiply-accumulate pass over the taps
// and owns the valid flag of the response register.
// ----------------------------------------------------------------------------
module fir_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fir_pkg::cmd_type    cmd,
   input  fir_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  fir_pkg::OP_LOAD_COEF: begin
                     cmd.load_coef = 1'b1;
                  end
                  fir_pkg::OP_PUSH_SAMPLE: begin
                     cmd.push_sample = 1'b1;
                     state_in        = ST_CHECK;
                  end
                  fir_pkg::OP_CLEAR_HISTORY: begin
                     cmd.clear_history = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (status.window_full) begin
               cmd.start_mac = 1'b1;
               state_in      = ST_RUN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            cmd.issue_mac = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.mac_busy && (!rsp_valid_ff || !rsp_stall)) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/fir_filter.sv
// ----------------------------------------------------------------------------
// FIR filter
// Direct-form FIR filter with loadable coefficients and a full-precision sum.
// ----------------------------------------------------------------------------
// Each request beat loads one coefficient, pushes one sample or clears the
// sample history. Loads, clears and unused opcodes do not stall the request
// port. A push that does not yet complete the window passes through a check
// state and returns to idle. A push that gives a result holds the request
// port stalled while one shared multiply-accumulate unit steps through one
// tap per cycle, fed by registered reads from the coefficient and history
// memories, and until the result is published. A tap count of zero uses
// one tap, and a tap count above the memory depth uses the full depth.
// The result waits in an output register, so the block keeps accepting beats
// while it is stalled; only a following result must wait for it to drain.
// The sum is signed, scaled by 2^-46, and wraps at 56 bits.
// ----------------------------------------------------------------------------
module fir_filter #(
   parameter int MAX_TAPS     = fir_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = fir_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic [fir_pkg::COEF_INDEX_W-1:0]     req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]         req_coef_value,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fir_pkg::OUT_W-1:0]     rsp_filtered_value,
   input  logic                                 csr_write_enable,
   input  logic [fir_pkg::TAP_REG_W-1:0]        csr_write_data
);

   fir_pkg::cmd_type    cmd;
   fir_pkg::status_type status;

   fir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   fir_datapath #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_coef_index     (req_coef_index),
      .req_coef_value     (req_coef_value),
      .req_sample         (req_sample),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_filtered_value (rsp_filtered_value)
   );

endmodule
